// ===== rtl/eott_pkg.sv =====
package eott_pkg;

	localparam int TimeW = 63;
	localparam int CountW = 32;

	typedef enum logic [1:0] {
		ACT_CREATE = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_ERROR = 2'd1,
		STS_IDLE  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RMV_RD,
		ST_RMV_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [TimeW-1:0]  expiry;
		logic [TimeW-1:0]  period;
		logic              periodic;
		logic [CountW-1:0] seq_no;
		logic [CountW-1:0] count;
	} entry_t;

	function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
		input logic [TimeW-1:0] b);
		logic [TimeW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
	endfunction

endpackage

// ===== rtl/expiry_ordered_timer_table.sv =====
// create and tick scan all TIMER_SLOTS entries, one memory read per cycle:
// result strobe follows the scan through the DONE state, next start taken with the strobe
// remove: ST_RMV_RD, ST_RMV_CHK, then ST_DONE; out-of-range remove or unused action: straight to ST_DONE
// reset clears control at once, then a clearing pass over all TIMER_SLOTS valid bits holds busy
// results are registered and shown for one cycle under done; the receiver cannot stall
module expiry_ordered_timer_table #(
	parameter int TIMER_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [62:0] now,
	input  logic [62:0] period,
	input  logic        repeat_req,
	input  logic [5:0]  slot,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  result_slot,
	output logic        did_fire,
	output logic [31:0] fired_sequence,
	output logic [31:0] fired_total,
	output logic        was_periodic
);

	localparam int AW = $clog2(TIMER_SLOTS);
	localparam int CW = AW + 1;

	eott_pkg::state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic          pend_q;
	logic [AW-1:0] pidx_q;
	logic          found_q;
	logic [AW-1:0] best_q;
	eott_pkg::entry_t best_ent_q;
	logic [31:0]   next_seq_q;

	// captured request
	logic [1:0]    op_q;
	logic [62:0]   now_q;
	logic [62:0]   period_q;
	logic          rep_q;
	logic [5:0]    slot_q;
	logic [31:0]   seq_q;

	// result registers
	logic          done_q;
	logic [1:0]    status_q;
	logic [5:0]    rslot_q;
	logic          fire_q;
	logic [31:0]   rseq_q;
	logic [31:0]   rtot_q;
	logic          rper_q;

	logic [1:0]    res_status;
	logic [5:0]    res_slot;
	logic          res_fire;
	logic [31:0]   res_seq;
	logic [31:0]   res_tot;
	logic          res_per;

	// memories
	logic             valid_mem [TIMER_SLOTS];
	eott_pkg::entry_t ent_mem [TIMER_SLOTS];
	logic             vrd_q;
	eott_pkg::entry_t erd_q;

	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             v_we;
	logic [AW-1:0]    v_wa;
	logic             v_wd;
	logic             e_we;
	eott_pkg::entry_t e_wd;

	logic accept;
	logic scan_end;
	logic slot_ok;
	logic due;
	logic [62:0] reload;
	logic [62:0] create_exp;

	assign accept     = start && (state_q == eott_pkg::ST_IDLE);
	assign scan_end   = (cnt_q == CW'(TIMER_SLOTS));
	assign slot_ok    = (32'(slot) < TIMER_SLOTS);
	assign due        = found_q && !(best_ent_q.expiry > now_q);
	assign reload     = eott_pkg::sat_add(now_q, best_ent_q.period);
	assign create_exp = eott_pkg::sat_add(now_q, period_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eott_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = cnt_q[AW-1:0];
		v_we    = 1'b0;
		v_wa    = best_q;
		v_wd    = 1'b0;
		e_we    = 1'b0;
		e_wd    = best_ent_q;
		case (state_q)
			eott_pkg::ST_CLEAR: begin
				v_we = 1'b1;
				v_wa = cnt_q[AW-1:0];
				if (cnt_q == CW'(TIMER_SLOTS - 1)) begin
					state_d = eott_pkg::ST_IDLE;
				end
			end
			eott_pkg::ST_IDLE: begin
				if (start) begin
					case (action)
						eott_pkg::ACT_CREATE, eott_pkg::ACT_TICK: state_d = eott_pkg::ST_SCAN;
						eott_pkg::ACT_REMOVE: begin
							state_d = slot_ok ? eott_pkg::ST_RMV_RD : eott_pkg::ST_DONE;
						end
						default: state_d = eott_pkg::ST_DONE;
					endcase
				end
			end
			eott_pkg::ST_SCAN: begin
				rd_en = !scan_end;
				if (scan_end) begin
					state_d = eott_pkg::ST_DONE;
				end
			end
			eott_pkg::ST_RMV_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(slot_q);
				state_d = eott_pkg::ST_RMV_CHK;
			end
			eott_pkg::ST_RMV_CHK: begin
				state_d = eott_pkg::ST_DONE;
			end
			eott_pkg::ST_DONE: begin
				state_d = eott_pkg::ST_IDLE;
				case (op_q)
					eott_pkg::ACT_CREATE: begin
						v_we = found_q;
						v_wd = 1'b1;
						e_we = found_q;
						e_wd.expiry   = create_exp;
						e_wd.period   = period_q;
						e_wd.periodic = rep_q;
						e_wd.seq_no   = seq_q;
						e_wd.count    = '0;
					end
					eott_pkg::ACT_REMOVE: begin
						v_we = found_q;
					end
					eott_pkg::ACT_TICK: begin
						// one-shot frees the slot, looping timer is rescheduled
						v_we = due && !best_ent_q.periodic;
						e_we = due && best_ent_q.periodic;
						e_wd.expiry = reload;
						e_wd.count  = best_ent_q.count + 32'd1;
					end
					default: ;
				endcase
			end
			default: state_d = eott_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			vrd_q <= valid_mem[rd_addr];
			erd_q <= ent_mem[rd_addr];
		end
		if (v_we) begin
			valid_mem[v_wa] <= v_wd;
		end
		if (e_we) begin
			ent_mem[best_q] <= e_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			found_q    <= 1'b0;
			next_seq_q <= '0;
			done_q     <= 1'b0;
		end else begin
			pend_q <= (state_q == eott_pkg::ST_SCAN) && !scan_end;
			done_q <= (state_q == eott_pkg::ST_DONE);
			case (state_q)
				eott_pkg::ST_CLEAR: cnt_q <= cnt_q + CW'(1);
				eott_pkg::ST_IDLE: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					if (start && action == eott_pkg::ACT_CREATE) begin
						next_seq_q <= next_seq_q + 32'd1;
					end
				end
				eott_pkg::ST_SCAN: begin
					if (!scan_end) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (pend_q) begin
						if (op_q == eott_pkg::ACT_CREATE) begin
							if (!vrd_q && !found_q) begin
								found_q <= 1'b1;
							end
						end else if (vrd_q && (!found_q || erd_q.expiry < best_ent_q.expiry)) begin
							found_q <= 1'b1;
						end
					end
				end
				eott_pkg::ST_RMV_CHK: found_q <= vrd_q;
				default: ;
			endcase
		end
	end

	always_comb begin
		res_status = eott_pkg::STS_ERROR;
		res_slot   = '0;
		res_fire   = 1'b0;
		res_seq    = '0;
		res_tot    = '0;
		res_per    = 1'b0;
		case (op_q)
			eott_pkg::ACT_CREATE: begin
				if (found_q) begin
					res_status = eott_pkg::STS_OK;
					res_slot   = 6'(best_q);
					res_seq    = seq_q;
				end
			end
			eott_pkg::ACT_REMOVE: begin
				if (found_q) begin
					res_status = eott_pkg::STS_OK;
					res_slot   = 6'(best_q);
				end
			end
			eott_pkg::ACT_TICK: begin
				if (due) begin
					res_status = eott_pkg::STS_OK;
					res_slot   = 6'(best_q);
					res_fire   = 1'b1;
					res_seq    = best_ent_q.seq_no;
					res_per    = best_ent_q.periodic;
					res_tot    = best_ent_q.periodic ? best_ent_q.count + 32'd1
						: best_ent_q.count;
				end else begin
					res_status = eott_pkg::STS_IDLE;
				end
			end
			default: ;
		endcase
	end

	// payload side of the scan and the request capture
	always_ff @(posedge clk) begin
		pidx_q <= cnt_q[AW-1:0];
		if (accept) begin
			op_q     <= action;
			now_q    <= now;
			period_q <= period;
			rep_q    <= repeat_req;
			slot_q   <= slot;
			seq_q    <= next_seq_q;
		end
		if (state_q == eott_pkg::ST_SCAN && pend_q) begin
			if (op_q == eott_pkg::ACT_CREATE) begin
				if (!vrd_q && !found_q) begin
					best_q <= pidx_q;
				end
			end else if (vrd_q && (!found_q || erd_q.expiry < best_ent_q.expiry)) begin
				best_q     <= pidx_q;
				best_ent_q <= erd_q;
			end
		end
		if (state_q == eott_pkg::ST_RMV_CHK) begin
			best_q <= AW'(slot_q);
		end
		if (state_q == eott_pkg::ST_DONE) begin
			status_q <= res_status;
			rslot_q  <= res_slot;
			fire_q   <= res_fire;
			rseq_q   <= res_seq;
			rtot_q   <= res_tot;
			rper_q   <= res_per;
		end
	end

	assign busy           = (state_q != eott_pkg::ST_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign result_slot    = rslot_q;
	assign did_fire       = fire_q;
	assign fired_sequence = rseq_q;
	assign fired_total    = rtot_q;
	assign was_periodic   = rper_q;

endmodule
